FILE: hw/rtl/mtu_pkg.sv
// Shared types and constants for the matrix transform unit.
// No dependencies.
package mtu_pkg;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_ROTX  = 3'd2;
  localparam logic [2:0] CMD_ROTY  = 3'd3;
  localparam logic [2:0] CMD_ROTZ  = 3'd4;
  localparam logic [2:0] CMD_TRANS = 3'd5;
  localparam logic [2:0] CMD_SCALE = 3'd6;

  localparam int TRIG_BITS    = 24;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_START = 34'sd10188014;

  // Arctangent table, 2^-32 turn units.
  function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
    logic signed [33:0] r;
    unique case (i)
      4'd0:  r = 34'sd536870912;
      4'd1:  r = 34'sd316933406;
      4'd2:  r = 34'sd167458907;
      4'd3:  r = 34'sd85004756;
      4'd4:  r = 34'sd42667331;
      4'd5:  r = 34'sd21354465;
      4'd6:  r = 34'sd10679838;
      4'd7:  r = 34'sd5340245;
      4'd8:  r = 34'sd2670163;
      4'd9:  r = 34'sd1335087;
      4'd10: r = 34'sd667544;
      4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;
      4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WRITE, OP_READ, OP_CORDIC, OP_QUAD,
    OP_MUL1, OP_MUL2, OP_STORE, OP_TRANS, OP_SCALE_MUL, OP_SCALE_ST, OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx_a;  // entry or CORDIC step
    logic [3:0] idx_b;
    logic [1:0] coef;   // which coefficient pair for mixing
  } dp_cmd_t;

endpackage

FILE: hw/rtl/mtu_ctrl.sv
// Controller FSM: sequences one command through the datapath.
// Depends on mtu_pkg.
module mtu_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [2:0]              in_cmd,
  input  logic                    out_busy,
  output logic                    in_ready,
  output logic                    done,
  output mtu_pkg::dp_cmd_t        cmd
);
  import mtu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_QUAD = 3'd2;
  localparam logic [2:0] S_ROW  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] op;
  logic [3:0] cnt, cnt_next;
  logic [3:0] u, v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      op    <= CMD_READ;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (in_fire) op <= in_cmd;
    end
  end

  // Column pair mixed by each rotation.
  always_comb begin
    unique case (op)
      CMD_ROTX: begin u = 4'd1; v = 4'd2; end
      CMD_ROTY: begin u = 4'd0; v = 4'd2; end
      default:  begin u = 4'd0; v = 4'd1; end
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_busy;

  // Row steps: cnt[3:2] row, cnt[1:0] phase (mul u', mul v', store).
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    done       = 1'b0;
    cmd        = '{op: OP_NONE, idx_a: 4'd0, idx_b: 4'd0, coef: 2'd0};
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cnt_next = '0;
          unique case (in_cmd)
            CMD_ROTX, CMD_ROTY, CMD_ROTZ: begin
              cmd.op = OP_LOAD;
              state_next = S_CORD;
            end
            CMD_WRITE: begin cmd.op = OP_WRITE; state_next = S_DONE; end
            CMD_READ:  begin cmd.op = OP_READ;  state_next = S_DONE; end
            CMD_TRANS: begin cmd.op = OP_TRANS; state_next = S_DONE; end
            CMD_SCALE: begin cmd.op = OP_SCALE_MUL; state_next = S_ROW; end
            default:   begin cmd.op = OP_CLEAR; state_next = S_DONE; end
          endcase
        end
      end
      S_CORD: begin
        cmd.op = OP_CORDIC;
        cmd.idx_a = cnt;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'(CORDIC_STEPS - 1)) state_next = S_QUAD;
      end
      S_QUAD: begin
        cmd.op = OP_QUAD;
        cnt_next = '0;
        state_next = S_ROW;
      end
      S_ROW: begin
        if (op == CMD_SCALE) begin
          // cnt 0..2: store diag, multiply next
          cmd.op = OP_SCALE_ST;
          cmd.idx_a = cnt;
          cnt_next = cnt + 4'd1;
          if (cnt == 4'd2) state_next = S_DONE;
        end else begin
          cmd.idx_a = {cnt[3:2], 2'b00} + u;
          cmd.idx_b = {cnt[3:2], 2'b00} + v;
          unique case (cnt[1:0])
            2'd0: begin cmd.op = OP_MUL1; cmd.coef = 2'd0; end
            2'd1: begin cmd.op = OP_MUL2; cmd.coef = 2'd1; end
            default: cmd.op = OP_STORE;
          endcase
          if (cnt[1:0] == 2'd2) begin
            cnt_next = {cnt[3:2] + 2'd1, 2'b00};
            if (cnt[3:2] == 2'd3) state_next = S_DONE;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/mtu_datapath.sv
// Datapath: matrix registers, CORDIC, multipliers, rounding and clamping.
// Depends on mtu_pkg.
module mtu_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mtu_pkg::dp_cmd_t        cmd,
  input  logic [2:0]              in_cmd,
  input  logic [3:0]              entry_index,
  input  logic signed [31:0]      write_value,
  input  logic [15:0]             angle,
  input  logic signed [31:0]      x_amount,
  input  logic signed [31:0]      y_amount,
  input  logic signed [31:0]      z_amount,
  output logic signed [31:0]      read_value,
  output logic                    saturated
);
  import mtu_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] m [16];
  logic signed [33:0] cx, cy, cz;
  logic signed [33:0] cos_v, sin_v;
  logic [1:0]         quad;
  logic [2:0]         op_cmd;
  logic signed [31:0] fx, fy, fz;
  logic signed [63:0] prod1, acc;
  logic signed [31:0] nu;

  // CORDIC step
  logic signed [33:0] sx, sy;
  assign sx = cx >>> cmd.idx_a;
  assign sy = cy >>> cmd.idx_a;

  // Start residual, wrapped into [-1/8, 1/8) turn
  logic [15:0] qa;
  logic [1:0]  q0;
  logic signed [15:0] res;
  assign qa  = angle + 16'h2000;
  assign q0  = qa[15:14];
  assign res = $signed(angle - {q0, 14'd0});

  // Coefficients: u' = a*c + b*(su ? s : -s), v' = a*(su ? -s : s) + b*c
  logic su;
  assign su = (op_cmd != CMD_ROTY);
  logic signed [33:0] ka, kb;
  always_comb begin
    if (cmd.coef == 2'd0) begin
      ka = cos_v; kb = su ? sin_v : -sin_v;
    end else begin
      ka = su ? -sin_v : sin_v; kb = cos_v;
    end
  end

  logic signed [31:0] ea, eb;
  assign ea = m[cmd.idx_a];
  assign eb = m[cmd.idx_b];

  // Two 32x34 products: pa and pb
  logic signed [63:0] pa, pb;
  assign pa = 64'(ea * ka);
  assign pb = 64'(eb * kb);

  function automatic logic signed [31:0] clamp(input logic signed [65:0] v,
                                                output logic s);
    s = 1'b0;
    if (v > 66'sh7FFFFFFF) begin s = 1'b1; return 32'sh7FFFFFFF; end
    if (v < -66'sh80000000) begin s = 1'b1; return -32'sh80000000; end
    return v[31:0];
  endfunction

  logic signed [65:0] rot_sum, rot_sh;
  assign rot_sum = 66'(prod1) + 66'(acc) + (66'sd1 <<< (TRIG_BITS - 1));
  assign rot_sh  = rot_sum >>> TRIG_BITS;

  // Scale: diag index by step
  logic [3:0]         didx;
  logic signed [31:0] dfac;
  always_comb begin
    unique case (cmd.idx_a[1:0])
      2'd0:    begin didx = 4'd0;  dfac = fx; end
      2'd1:    begin didx = 4'd5;  dfac = fy; end
      default: begin didx = 4'd10; dfac = fz; end
    endcase
  end
  logic signed [63:0] sprod;
  assign sprod = 64'(m[didx] * dfac);
  logic signed [65:0] s_sh;
  assign s_sh = (66'(sprod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  logic signed [65:0] t0, t1, t2;
  assign t0 = 66'(m[12]) + 66'(x_amount);
  assign t1 = 66'(m[13]) + 66'(y_amount);
  assign t2 = 66'(m[14]) + 66'(z_amount);

  always_ff @(posedge clk) begin
    logic s0, s1, s2;
    logic signed [31:0] r0, r1, r2;
    if (rst) begin
      for (int i = 0; i < 16; i++) m[i] <= (i % 5 == 0) ? ONE : 32'sd0;
      saturated  <= 1'b0;
      read_value <= '0;
    end else begin
      unique case (cmd.op)
        OP_WRITE: begin
          m[entry_index] <= write_value;
          read_value <= '0; saturated <= 1'b0;
        end
        OP_READ: begin
          read_value <= m[entry_index]; saturated <= 1'b0;
        end
        OP_TRANS: begin
          r0 = clamp(t0, s0); r1 = clamp(t1, s1); r2 = clamp(t2, s2);
          m[12] <= r0; m[13] <= r1; m[14] <= r2;
          read_value <= '0; saturated <= s0 | s1 | s2;
        end
        OP_LOAD: begin
          op_cmd <= in_cmd;
          quad <= q0;
          cx <= CORDIC_START; cy <= '0;
          cz <= 34'(res) <<< 16;
          read_value <= '0; saturated <= 1'b0;
        end
        OP_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - sy; cy <= cy + sx; cz <= cz - atan_turn(cmd.idx_a);
          end else begin
            cx <= cx + sy; cy <= cy - sx; cz <= cz + atan_turn(cmd.idx_a);
          end
        end
        OP_QUAD: begin
          unique case (quad)
            2'd0: begin cos_v <= cx;  sin_v <= cy;  end
            2'd1: begin cos_v <= -cy; sin_v <= cx;  end
            2'd2: begin cos_v <= -cx; sin_v <= -cy; end
            default: begin cos_v <= cy; sin_v <= -cx; end
          endcase
        end
        OP_MUL1: begin
          prod1 <= pa; acc <= pb;
        end
        OP_MUL2: begin
          r0 = clamp(rot_sh, s0);
          nu <= r0;
          saturated <= saturated | s0;
          prod1 <= pa; acc <= pb;
        end
        OP_STORE: begin
          r1 = clamp(rot_sh, s1);
          m[cmd.idx_a] <= nu;
          m[cmd.idx_b] <= r1;
          saturated <= saturated | s1;
        end
        OP_SCALE_MUL: begin
          fx <= x_amount; fy <= y_amount; fz <= z_amount;
          op_cmd <= in_cmd;
          read_value <= '0; saturated <= 1'b0;
        end
        OP_SCALE_ST: begin
          r2 = clamp(s_sh, s2);
          m[didx] <= r2;
          saturated <= saturated | s2;
        end
        // Unused command: answer zeros
        OP_CLEAR: begin
          read_value <= '0; saturated <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/matrix_transform_unit_core.sv
// Matrix transform unit: 4x4 Q-format matrix with write/read/rotate/translate/scale.
// Rotate runs 16 CORDIC steps, quadrant fixup, 12 row steps through the multipliers, then done;
// scale runs the diagonal stores, then done; read/write/translate/unused go straight to done.
// One command at a time: a new one is accepted only when idle and the output slot is empty.
// Reset (rst, synchronous) loads the identity matrix and clears the output slot.
// Depends on mtu_pkg, mtu_ctrl, mtu_datapath.
module matrix_transform_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] command, [6:3] entry_index, [38:7] write_value, [54:39] angle,
  // [86:55] x_amount, [118:87] y_amount, [150:119] z_amount
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] read_value, [32] saturated
  output logic [39:0]  m_tdata
);
  import mtu_pkg::*;

  dp_cmd_t            cmd;
  logic               in_fire, done;
  logic signed [31:0] read_value;
  logic               saturated;

  assign in_fire = s_tvalid && s_tready;

  mtu_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_cmd(s_tdata[2:0]), .out_busy(m_tvalid),
    .in_ready(s_tready), .done, .cmd
  );

  mtu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .in_cmd(s_tdata[2:0]),
    .entry_index(s_tdata[6:3]),
    .write_value(s_tdata[38:7]),
    .angle(s_tdata[54:39]),
    .x_amount(s_tdata[86:55]),
    .y_amount(s_tdata[118:87]),
    .z_amount(s_tdata[150:119]),
    .read_value, .saturated
  );

  // Output register holds the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, saturated, read_value};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule
